// ----- design/battery_thermal_command_gateway_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the battery thermal command gateway
// Shared forms for the concurrent checks used by the gateway RTL.
// ----------------------------------------------------------------------------
`ifndef BATTERY_THERMAL_COMMAND_GATEWAY_ASSERT_SVH
`define BATTERY_THERMAL_COMMAND_GATEWAY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btcg same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btcg next-cycle check failed");

`endif

// ----- design/btcg_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery thermal command gateway package
// Frame identifiers, command field constants, codes and shared types.
// ----------------------------------------------------------------------------
package btcg_pkg;

  localparam logic [28:0] MON_BASE_ID  = 29'h19B50000;
  localparam logic [28:0] MON_VOLT_OFS = 29'h0009;
  localparam logic [28:0] MON_TEMP_OFS = 29'h0008;
  localparam logic [28:0] CMD_ID       = 29'h18FF45F4;

  localparam logic [15:0] PACK_VOLT    = 16'd340;
  localparam logic [8:0]  TEMP_OFFSET  = 9'd100;
  localparam logic [3:0]  TEMP_MIN_LEN = 4'd3;
  localparam logic [3:0]  REQ_LEN      = 4'd0;
  localparam logic [3:0]  CMD_LEN      = 4'd8;
  localparam logic [1:0]  RELAY_FIELD  = 2'b01;
  localparam logic [16:0] AGE_SAT      = 17'h10000;

  localparam logic signed [9:0] SET_DELTA = 10'sd20;
  localparam logic signed [9:0] SET_IDLE  = 10'sd25;
  localparam logic signed [9:0] SET_MIN   = 10'sd1;
  localparam logic signed [9:0] SET_MAX   = 10'sd50;
  localparam logic [7:0]        SET_OFFSET = 8'd40;

  typedef enum logic [2:0] {
    CFG_MANUAL_ENABLE = 3'd0,
    CFG_MANUAL_MODE   = 3'd1,
    CFG_MANUAL_SET    = 3'd2,
    CFG_HEAT_BELOW    = 3'd3,
    CFG_COOL_ABOVE    = 3'd4,
    CFG_STALE_LIMIT   = 3'd5,
    CFG_REQ_PERIOD    = 3'd6,
    CFG_CMD_PERIOD    = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_SHUTDOWN = 2'd0,
    MODE_COOL     = 2'd1,
    MODE_HEAT     = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  // Inputs of the command decision.
  typedef struct packed {
    logic              manual_enable;
    logic [1:0]        manual_mode;
    logic [5:0]        manual_set_temp;
    logic signed [8:0] heat_below;
    logic signed [8:0] cool_above;
    logic              temp_valid;
    logic signed [8:0] average_temp;
  } cmd_ctrl_t;

  // Outcome of the command decision.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] set_byte;
    logic       auto_used;
  } cmd_info_t;

  function automatic logic [5:0] clamp_set(input logic signed [9:0] v);
    logic signed [9:0] c;
    begin
      if (v < SET_MIN) begin
        c = SET_MIN;
      end else if (v > SET_MAX) begin
        c = SET_MAX;
      end else begin
        c = v;
      end
      return c[5:0];
    end
  endfunction

endpackage

// ----- design/btcg_cmd_build.sv -----
// ----------------------------------------------------------------------------
// Thermal command decision
// Chooses mode and set point from manual settings or the stored temperature.
// ----------------------------------------------------------------------------
module btcg_cmd_build (
  input  btcg_pkg::cmd_ctrl_t ctrl,
  output btcg_pkg::cmd_info_t info
);

  logic signed [9:0] avg_ext;
  logic signed [9:0] set_raw;
  logic [5:0]        set_clamped;

  assign avg_ext = 10'(ctrl.average_temp);

  always_comb begin
    info.mode      = btcg_pkg::MODE_SHUTDOWN;
    info.auto_used = 1'b0;
    set_raw        = btcg_pkg::SET_IDLE;
    priority if (ctrl.manual_enable) begin
      info.mode = ctrl.manual_mode;
      set_raw   = signed'({4'b0000, ctrl.manual_set_temp});
    end else if (ctrl.temp_valid) begin
      info.auto_used = 1'b1;
      if (ctrl.average_temp < ctrl.heat_below) begin
        info.mode = btcg_pkg::MODE_HEAT;
        set_raw   = avg_ext + btcg_pkg::SET_DELTA;
      end else if (ctrl.average_temp > ctrl.cool_above) begin
        info.mode = btcg_pkg::MODE_COOL;
        set_raw   = avg_ext - btcg_pkg::SET_DELTA;
      end
    end else begin
      // A stale or absent temperature shuts the unit down at the idle set point.
      set_raw = btcg_pkg::SET_IDLE;
    end
    set_clamped   = btcg_pkg::clamp_set(set_raw);
    info.set_byte = {2'b00, set_clamped} + btcg_pkg::SET_OFFSET;
  end

endmodule

// ----- design/battery_thermal_command_gateway.sv -----
// ----------------------------------------------------------------------------
// Battery thermal command gateway
// Turns millisecond ticks and monitor frames into request and command frames.
// ----------------------------------------------------------------------------
// Output: the first result of a tick shows on the output in the cycle after the
//   tick is accepted; further results of the same tick follow one per cycle
//   unless out_stall holds them. Input: one request per cycle while in_stall is low;
//   a tick that fires holds the input until its last result (one to four) leaves.
// Reset: synchronous and active low; configuration returns to its defaults and
//   all timers, the temperature record and the life counter clear at once.
// ----------------------------------------------------------------------------
`include "battery_thermal_command_gateway_assert.svh"

module battery_thermal_command_gateway (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [28:0] in_frame_id,
  input  logic [3:0]  in_frame_len,
  input  logic [63:0] in_frame_data,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_bus_select,
  output logic [28:0] out_id,
  output logic [3:0]  out_len,
  output logic [63:0] out_data,
  output logic        out_auto_logic_used,
  output logic        out_last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers. The port never stalls a write.
  // --------------------------------------------------------------------------
  logic              manual_enable_r;
  logic [1:0]        manual_mode_r;
  logic [5:0]        manual_set_temp_r;
  logic signed [8:0] heat_below_r;
  logic signed [8:0] cool_above_r;
  logic [15:0]       stale_limit_r;
  logic [15:0]       request_period_r;
  logic [15:0]       command_period_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_enable_r   <= 1'b0;
      manual_mode_r     <= btcg_pkg::MODE_SHUTDOWN;
      manual_set_temp_r <= 6'd25;
      heat_below_r      <= 9'sd22;
      cool_above_r      <= 9'sd28;
      stale_limit_r     <= 16'd3000;
      request_period_r  <= 16'd500;
      command_period_r  <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (btcg_pkg::cfg_index_t'(cfg_index))
        btcg_pkg::CFG_MANUAL_ENABLE: manual_enable_r   <= cfg_data[0];
        btcg_pkg::CFG_MANUAL_MODE:   manual_mode_r     <= cfg_data[1:0];
        btcg_pkg::CFG_MANUAL_SET:    manual_set_temp_r <= cfg_data[5:0];
        btcg_pkg::CFG_HEAT_BELOW:    heat_below_r      <= signed'(cfg_data[8:0]);
        btcg_pkg::CFG_COOL_ABOVE:    cool_above_r      <= signed'(cfg_data[8:0]);
        btcg_pkg::CFG_STALE_LIMIT:   stale_limit_r     <= cfg_data;
        btcg_pkg::CFG_REQ_PERIOD:    request_period_r  <= cfg_data;
        btcg_pkg::CFG_CMD_PERIOD:    command_period_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output burst registers. A tick loads up to three pending requests and one
  // pending command; they leave one per cycle while out_stall is low, requests first.
  // --------------------------------------------------------------------------
  logic [1:0]  req_cnt_r,   req_cnt_nxt;
  logic        cmd_pend_r,  cmd_pend_nxt;
  logic [63:0] cmd_data_r,  cmd_data_nxt;
  logic        cmd_auto_r,  cmd_auto_nxt;

  logic out_take;
  logic in_take;
  logic tick_take;
  logic frame_take;

  assign out_valid = (req_cnt_r != 2'd0) || cmd_pend_r;
  assign out_last  = ((req_cnt_r == 2'd1) && !cmd_pend_r) ||
                     ((req_cnt_r == 2'd0) && cmd_pend_r);
  assign out_take  = out_valid && !out_stall;

  // A new request enters once the burst is empty or its final frame leaves.
  assign in_stall   = out_valid && !(out_take && out_last);
  assign in_take    = in_valid && !in_stall;
  assign tick_take  = in_take && !in_action;
  assign frame_take = in_take && in_action;

  always_comb begin
    out_bus_select      = 1'b0;
    out_len             = btcg_pkg::REQ_LEN;
    out_data            = 64'd0;
    out_auto_logic_used = 1'b0;
    unique case (req_cnt_r)
      2'd3: out_id = btcg_pkg::MON_BASE_ID;
      2'd2: out_id = btcg_pkg::MON_BASE_ID + btcg_pkg::MON_VOLT_OFS;
      2'd1: out_id = btcg_pkg::MON_BASE_ID + btcg_pkg::MON_TEMP_OFS;
      default: begin
        out_id              = btcg_pkg::CMD_ID;
        out_bus_select      = 1'b1;
        out_len             = btcg_pkg::CMD_LEN;
        out_data            = cmd_data_r;
        out_auto_logic_used = cmd_auto_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Gateway state: temperature record, age, period timers and life counter.
  // --------------------------------------------------------------------------
  logic signed [8:0] average_temp_r,  average_temp_nxt;
  logic              temp_seen_r,     temp_seen_nxt;
  logic [16:0]       temp_age_r,      temp_age_nxt;
  logic [7:0]        life_counter_r,  life_counter_nxt;
  logic [15:0]       request_timer_r, request_timer_nxt;
  logic [15:0]       command_timer_r, command_timer_nxt;

  logic [16:0] age_inc;
  logic [15:0] req_inc;
  logic [15:0] cmd_inc;
  logic        req_fire;
  logic        cmd_fire;
  logic        temp_frame;

  assign age_inc  = (temp_age_r < btcg_pkg::AGE_SAT) ? temp_age_r + 17'd1 : temp_age_r;
  assign req_inc  = request_timer_r + 16'd1;
  assign cmd_inc  = command_timer_r + 16'd1;
  assign req_fire = req_inc >= request_period_r;
  assign cmd_fire = cmd_inc >= command_period_r;

  assign temp_frame = (in_frame_id == btcg_pkg::MON_BASE_ID + btcg_pkg::MON_TEMP_OFS) &&
                      (in_frame_len >= btcg_pkg::TEMP_MIN_LEN);

  // The command decision sees the age as it stands after this tick.
  btcg_pkg::cmd_ctrl_t cmd_ctrl;
  btcg_pkg::cmd_info_t cmd_info;

  assign cmd_ctrl.manual_enable   = manual_enable_r;
  assign cmd_ctrl.manual_mode     = manual_mode_r;
  assign cmd_ctrl.manual_set_temp = manual_set_temp_r;
  assign cmd_ctrl.heat_below      = heat_below_r;
  assign cmd_ctrl.cool_above      = cool_above_r;
  assign cmd_ctrl.temp_valid      = temp_seen_r && (age_inc <= {1'b0, stale_limit_r});
  assign cmd_ctrl.average_temp    = average_temp_r;

  btcg_cmd_build u_cmd_build (
    .ctrl (cmd_ctrl),
    .info (cmd_info)
  );

  always_comb begin
    average_temp_nxt  = average_temp_r;
    temp_seen_nxt     = temp_seen_r;
    temp_age_nxt      = temp_age_r;
    life_counter_nxt  = life_counter_r;
    request_timer_nxt = request_timer_r;
    command_timer_nxt = command_timer_r;
    req_cnt_nxt       = req_cnt_r;
    cmd_pend_nxt      = cmd_pend_r;
    cmd_data_nxt      = cmd_data_r;
    cmd_auto_nxt      = cmd_auto_r;

    // Advance through the burst as frames leave.
    if (out_take) begin
      if (req_cnt_r != 2'd0) begin
        req_cnt_nxt = req_cnt_r - 2'd1;
      end else begin
        cmd_pend_nxt = 1'b0;
      end
    end

    if (frame_take && temp_frame) begin
      average_temp_nxt = signed'({1'b0, in_frame_data[47:40]} - btcg_pkg::TEMP_OFFSET);
      temp_seen_nxt    = 1'b1;
      temp_age_nxt     = 17'd0;
    end

    if (tick_take) begin
      temp_age_nxt      = age_inc;
      request_timer_nxt = req_fire ? 16'd0 : req_inc;
      command_timer_nxt = cmd_fire ? 16'd0 : cmd_inc;
      req_cnt_nxt       = req_fire ? 2'd3 : 2'd0;
      cmd_pend_nxt      = cmd_fire;
      if (cmd_fire) begin
        cmd_auto_nxt     = cmd_info.auto_used;
        cmd_data_nxt     = {btcg_pkg::RELAY_FIELD, 4'b0000, cmd_info.mode,
                            btcg_pkg::PACK_VOLT,
                            8'd0,
                            cmd_info.set_byte,
                            8'd0,
                            life_counter_r,
                            8'd0};
        life_counter_nxt = life_counter_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      average_temp_r  <= 9'sd0;
      temp_seen_r     <= 1'b0;
      temp_age_r      <= 17'd0;
      life_counter_r  <= 8'd0;
      request_timer_r <= 16'd0;
      command_timer_r <= 16'd0;
      req_cnt_r       <= 2'd0;
      cmd_pend_r      <= 1'b0;
    end else begin
      average_temp_r  <= average_temp_nxt;
      temp_seen_r     <= temp_seen_nxt;
      temp_age_r      <= temp_age_nxt;
      life_counter_r  <= life_counter_nxt;
      request_timer_r <= request_timer_nxt;
      command_timer_r <= command_timer_nxt;
      req_cnt_r       <= req_cnt_nxt;
      cmd_pend_r      <= cmd_pend_nxt;
    end
  end

  // Command payload needs no reset: it only matters while a command is pending.
  always_ff @(posedge clk) begin
    cmd_data_r <= cmd_data_nxt;
    cmd_auto_r <= cmd_auto_nxt;
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `BTCG_ASSERT_NOW(a_req_on_monitor_bus, clk, rst_n, out_valid && (req_cnt_r != 2'd0), !out_bus_select && (out_len == btcg_pkg::REQ_LEN))
  `BTCG_ASSERT_NOW(a_last_ends_burst, clk, rst_n, out_valid && out_last, req_cnt_r <= 2'd1)
  `BTCG_ASSERT_NEXT(a_life_steps, clk, rst_n, tick_take && cmd_fire, life_counter_r == $past(life_counter_r) + 8'd1)
  `BTCG_ASSERT_NEXT(a_burst_opens, clk, rst_n, tick_take && req_fire, out_valid && (out_id == btcg_pkg::MON_BASE_ID))

endmodule
